### rtl/sensor_frame_reassembler_defines.svh
// assertion macros shared by the sensor frame reassembler rtl
`ifndef SENSOR_FRAME_REASSEMBLER_DEFINES_SVH
`define SENSOR_FRAME_REASSEMBLER_DEFINES_SVH

// check on clk_i, switched off while rst_ni is low
`define SFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on clk_i that also holds while reset is applied
`define SFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/sfr_pkg.sv
// types, constants and codes shared by the sensor frame reassembler
`default_nettype none

package sfr_pkg;

  // default sizing of the pixel stores and frame unpacking
  localparam int unsigned PIXEL_COUNT_DEF     = 3648;
  localparam int unsigned BITS_PER_FRAME_DEF  = 56;
  localparam int unsigned BYTES_PER_FRAME_DEF = 6;

  // write index wide enough for any byte frame number times six
  localparam int unsigned IDX_W  = 20;
  // element counter inside one frame, up to 56 elements
  localparam int unsigned ELEM_W = 6;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_ID      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_ID      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ID     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_CODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_CODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_NEEDED  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_NEEDED = 3'd6;

  // register reset values
  localparam logic [10:0] ACK_ID_RST      = 11'd257;
  localparam logic [10:0] BIN_ID_RST      = 11'd258;
  localparam logic [10:0] BYTE_ID_RST     = 11'd259;
  localparam logic [7:0]  BIN_CODE_RST    = 8'd1;
  localparam logic [7:0]  BYTE_CODE_RST   = 8'd2;
  localparam logic [15:0] BIN_NEEDED_RST  = 16'd66;
  localparam logic [15:0] BYTE_NEEDED_RST = 16'd608;

  // item command codes
  localparam logic [1:0] CMD_FRAME     = 2'd0;
  localparam logic [1:0] CMD_READ_BIT  = 2'd1;
  localparam logic [1:0] CMD_READ_BYTE = 2'd2;

  // frame length codes that matter
  localparam logic [3:0] LEN_ACK_MIN = 4'd2;
  localparam logic [3:0] LEN_DATA    = 4'd8;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_BIN_WR,
    ST_BYTE_WR,
    ST_WIPE,
    ST_RESULT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ACK,
    KIND_BIN_DATA,
    KIND_BYTE_DATA,
    KIND_READ_BIT,
    KIND_READ_BYTE
  } item_kind_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [10:0]      bus_id;
    logic [3:0]       length;
    logic [7:0][7:0]  bytes;
    logic [11:0]      pixel_index;
  } item_t;

  typedef struct packed {
    logic        success_flag;
    logic        active_flag;
    logic        ready_flag;
    logic [15:0] frame_count;
    logic [15:0] last_number;
    logic [7:0]  pixel_value;
  } result_t;

  typedef struct packed {
    logic load_item;
    logic ack_apply;
    logic load_base;
    logic write_bit;
    logic write_byte;
    logic count_frame;
    logic clear_step;
    logic read_issue;
    logic load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    item_kind_e kind;
    logic       ack_start;
    logic       bit_last;
    logic       byte_last;
    logic       clr_last;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/sfr_if.sv
// valid/ready channel interfaces for items, results and register writes
`default_nettype none

interface sfr_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [10:0] bus_id;
  logic [3:0]  length;
  logic [7:0]  byte0;
  logic [7:0]  byte1;
  logic [7:0]  byte2;
  logic [7:0]  byte3;
  logic [7:0]  byte4;
  logic [7:0]  byte5;
  logic [7:0]  byte6;
  logic [7:0]  byte7;
  logic [11:0] pixel_index;

  modport source (
    output valid, cmd, bus_id, length, byte0, byte1, byte2, byte3,
           byte4, byte5, byte6, byte7, pixel_index,
    input  ready
  );
  modport sink (
    input  valid, cmd, bus_id, length, byte0, byte1, byte2, byte3,
           byte4, byte5, byte6, byte7, pixel_index,
    output ready
  );
endinterface

interface sfr_result_if;
  logic        valid;
  logic        ready;
  logic        success_flag;
  logic        active_flag;
  logic        ready_flag;
  logic [15:0] frame_count;
  logic [15:0] last_number;
  logic [7:0]  pixel_value;

  modport source (
    output valid, success_flag, active_flag, ready_flag, frame_count,
           last_number, pixel_value,
    input  ready
  );
  modport sink (
    input  valid, success_flag, active_flag, ready_flag, frame_count,
           last_number, pixel_value,
    output ready
  );
endinterface

interface sfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

### rtl/sfr_ram.sv
// generic single write port ram with registered read
`default_nettype none

module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = sfr_pkg::PIXEL_COUNT_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/sfr_dpath.sv
// datapath: registers, item decode, pixel stores and result register
`default_nettype none

module sfr_dpath #(
  parameter int unsigned PIXEL_COUNT     = sfr_pkg::PIXEL_COUNT_DEF,
  parameter int unsigned BITS_PER_FRAME  = sfr_pkg::BITS_PER_FRAME_DEF,
  parameter int unsigned BYTES_PER_FRAME = sfr_pkg::BYTES_PER_FRAME_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  sfr_pkg::item_t                  item_i,
  input  sfr_pkg::ctrl_cmd_t              cmd_i,
  output sfr_pkg::dp_status_t             status_o,
  output sfr_pkg::result_t                result_o
);
  import sfr_pkg::*;

  localparam int unsigned AW = $clog2(PIXEL_COUNT);

  // configuration registers
  logic [10:0] ack_id_q, bin_id_q, byte_id_q;
  logic [7:0]  bin_code_q, byte_code_q;
  logic [15:0] bin_need_q, byte_need_q;

  // capture state
  logic        success_q, success_d;
  logic        acq_q, acq_d;
  logic        rdy_q, rdy_d;
  logic        bin_wait_q, bin_wait_d;
  logic        byte_wait_q, byte_wait_d;
  logic        wipe_bin_q, wipe_bin_d;
  logic        wipe_byte_q, wipe_byte_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] last_q, last_d;

  // item and walk registers
  item_t             item_q;
  logic [IDX_W-1:0]  idx_q;
  logic [ELEM_W-1:0] elem_q;
  logic [AW-1:0]     clr_q;
  result_t           result_q;

  // decode signals
  item_kind_e        kind;
  logic              is_ack, is_bin, is_byte;
  logic              code_bin, code_byte, ack_ok;
  logic [IDX_W-1:0]  base_bin, base_byte, pix_ext;
  logic              idx_ok, pix_ok;
  logic [55:0]       bits_v;
  logic [2:0]        byte_sel;
  logic [15:0]       number, cnt_inc, need;
  logic              clr_last;

  // store ports
  logic          bit_we, byte_we;
  logic [AW-1:0] waddr, raddr;
  logic          bit_wdata, bit_rdata;
  logic [7:0]    byte_wdata, byte_rdata;
  logic [7:0]    pixel;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_id_q    <= ACK_ID_RST;
      bin_id_q    <= BIN_ID_RST;
      byte_id_q   <= BYTE_ID_RST;
      bin_code_q  <= BIN_CODE_RST;
      byte_code_q <= BYTE_CODE_RST;
      bin_need_q  <= BIN_NEEDED_RST;
      byte_need_q <= BYTE_NEEDED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACK_ID:      ack_id_q    <= cfg_data_i[10:0];
        CFG_BIN_ID:      bin_id_q    <= cfg_data_i[10:0];
        CFG_BYTE_ID:     byte_id_q   <= cfg_data_i[10:0];
        CFG_BIN_CODE:    bin_code_q  <= cfg_data_i[7:0];
        CFG_BYTE_CODE:   byte_code_q <= cfg_data_i[7:0];
        CFG_BIN_NEEDED:  bin_need_q  <= cfg_data_i;
        CFG_BYTE_NEEDED: byte_need_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_i;
    end
  end

  // item classification
  always_comb begin
    code_bin  = item_q.bytes[0] == bin_code_q;
    code_byte = item_q.bytes[0] == byte_code_q;
    ack_ok    = item_q.bytes[1] != 8'd0;
    is_ack    = item_q.bus_id == ack_id_q && item_q.length >= LEN_ACK_MIN;
    is_bin    = !is_ack && item_q.bus_id == bin_id_q && bin_wait_q &&
                item_q.length == LEN_DATA;
    is_byte   = !is_ack && !is_bin && item_q.bus_id == byte_id_q && byte_wait_q &&
                item_q.length == LEN_DATA;
    case (item_q.cmd)
      CMD_FRAME: begin
        if (is_ack) begin
          kind = KIND_ACK;
        end else if (is_bin) begin
          kind = KIND_BIN_DATA;
        end else if (is_byte) begin
          kind = KIND_BYTE_DATA;
        end else begin
          kind = KIND_NONE;
        end
      end
      CMD_READ_BIT:  kind = KIND_READ_BIT;
      CMD_READ_BYTE: kind = KIND_READ_BYTE;
      default:       kind = KIND_NONE;
    endcase
  end

  // first pixel index of a data frame
  assign base_bin  = IDX_W'(item_q.bytes[0]) * IDX_W'(BITS_PER_FRAME);
  assign base_byte = IDX_W'({item_q.bytes[1], item_q.bytes[0]}) * IDX_W'(BYTES_PER_FRAME);

  // walk over the pixels of one frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      elem_q <= '0;
    end else if (cmd_i.load_base) begin
      idx_q  <= (kind == KIND_BIN_DATA) ? base_bin : base_byte;
      elem_q <= '0;
    end else if (cmd_i.write_bit || cmd_i.write_byte) begin
      idx_q  <= idx_q + IDX_W'(1);
      elem_q <= elem_q + ELEM_W'(1);
    end
  end

  // clearing sweep address
  assign clr_last = clr_q == AW'(PIXEL_COUNT - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_last ? '0 : clr_q + AW'(1);
    end
  end

  // frame counting values
  always_comb begin
    number  = cmd_i.write_bit ? {8'd0, item_q.bytes[0]}
                              : {item_q.bytes[1], item_q.bytes[0]};
    cnt_inc = (cnt_q != 16'hFFFF) ? cnt_q + 16'd1 : cnt_q;
    need    = cmd_i.write_bit ? bin_need_q : byte_need_q;
  end

  // capture flags and counters
  always_comb begin
    success_d   = success_q;
    acq_d       = acq_q;
    rdy_d       = rdy_q;
    bin_wait_d  = bin_wait_q;
    byte_wait_d = byte_wait_q;
    wipe_bin_d  = wipe_bin_q;
    wipe_byte_d = wipe_byte_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    if (cmd_i.ack_apply) begin
      success_d = ack_ok;
      if (code_bin || code_byte) begin
        if (ack_ok) begin
          bin_wait_d  = code_bin;
          byte_wait_d = !code_bin;
          wipe_bin_d  = code_bin;
          wipe_byte_d = !code_bin;
          acq_d       = 1'b1;
          rdy_d       = 1'b0;
          cnt_d       = '0;
          last_d      = '0;
        end else begin
          acq_d = 1'b0;
        end
      end
    end
    if (cmd_i.count_frame) begin
      last_d = number;
      cnt_d  = cnt_inc;
      if (cnt_inc >= need) begin
        acq_d = 1'b0;
        rdy_d = 1'b1;
        if (cmd_i.write_bit) begin
          bin_wait_d = 1'b0;
        end else begin
          byte_wait_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      success_q   <= 1'b0;
      acq_q       <= 1'b0;
      rdy_q       <= 1'b0;
      bin_wait_q  <= 1'b0;
      byte_wait_q <= 1'b0;
      wipe_bin_q  <= 1'b1;
      wipe_byte_q <= 1'b1;
      cnt_q       <= '0;
      last_q      <= '0;
    end else begin
      success_q   <= success_d;
      acq_q       <= acq_d;
      rdy_q       <= rdy_d;
      bin_wait_q  <= bin_wait_d;
      byte_wait_q <= byte_wait_d;
      wipe_bin_q  <= wipe_bin_d;
      wipe_byte_q <= wipe_byte_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
    end
  end

  // store write and read ports
  assign idx_ok   = idx_q < IDX_W'(PIXEL_COUNT);
  assign pix_ext  = IDX_W'(item_q.pixel_index);
  assign pix_ok   = pix_ext < IDX_W'(PIXEL_COUNT);
  assign bits_v   = item_q.bytes[7:1];
  assign byte_sel = elem_q[2:0] + 3'd2;

  assign waddr      = cmd_i.clear_step ? clr_q : idx_q[AW-1:0];
  assign raddr      = pix_ext[AW-1:0];
  assign bit_we     = (cmd_i.clear_step && wipe_bin_q) || (cmd_i.write_bit && idx_ok);
  assign byte_we    = (cmd_i.clear_step && wipe_byte_q) || (cmd_i.write_byte && idx_ok);
  assign bit_wdata  = cmd_i.clear_step ? 1'b0 : bits_v[elem_q];
  assign byte_wdata = cmd_i.clear_step ? 8'd0 : item_q.bytes[byte_sel];

  sfr_ram #(
    .WIDTH (1),
    .DEPTH (PIXEL_COUNT)
  ) u_bit_store (
    .clk_i   (clk_i),
    .we_i    (bit_we),
    .waddr_i (waddr),
    .wdata_i (bit_wdata),
    .re_i    (cmd_i.read_issue),
    .raddr_i (raddr),
    .rdata_o (bit_rdata)
  );

  sfr_ram #(
    .WIDTH (8),
    .DEPTH (PIXEL_COUNT)
  ) u_byte_store (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (waddr),
    .wdata_i (byte_wdata),
    .re_i    (cmd_i.read_issue),
    .raddr_i (raddr),
    .rdata_o (byte_rdata)
  );

  // pixel selection for read items
  always_comb begin
    pixel = 8'd0;
    if (pix_ok) begin
      case (item_q.cmd)
        CMD_READ_BIT:  pixel = {7'd0, bit_rdata};
        CMD_READ_BYTE: pixel = byte_rdata;
        default:       pixel = 8'd0;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      result_q.success_flag <= success_q;
      result_q.active_flag  <= acq_q;
      result_q.ready_flag   <= rdy_q;
      result_q.frame_count  <= cnt_q;
      result_q.last_number  <= last_q;
      result_q.pixel_value  <= pixel;
    end
  end

  assign result_o = result_q;

  // status towards the controller
  assign status_o.kind      = kind;
  assign status_o.ack_start = ack_ok && (code_bin || code_byte);
  assign status_o.bit_last  = elem_q == ELEM_W'(BITS_PER_FRAME - 1);
  assign status_o.byte_last = elem_q == ELEM_W'(BYTES_PER_FRAME - 1);
  assign status_o.clr_last  = clr_last;

endmodule

`default_nettype wire

### rtl/sfr_ctrl.sv
// controller: sequences clearing, decode, pixel writes and result hand-off
`default_nettype none
`include "sensor_frame_reassembler_defines.svh"

module sfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sfr_pkg::dp_status_t status_i,
  output sfr_pkg::ctrl_cmd_t  cmd_o
);
  import sfr_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (status_i.kind)
          KIND_ACK:       state_d = status_i.ack_start ? ST_WIPE : ST_RESULT;
          KIND_BIN_DATA:  state_d = ST_BIN_WR;
          KIND_BYTE_DATA: state_d = ST_BYTE_WR;
          default:        state_d = ST_RESULT;
        endcase
      end
      ST_BIN_WR: begin
        if (status_i.bit_last) state_d = ST_RESULT;
      end
      ST_BYTE_WR: begin
        if (status_i.byte_last) state_d = ST_RESULT;
      end
      ST_WIPE: begin
        if (status_i.clr_last) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.ack_apply  = status_i.kind == KIND_ACK;
        cmd_o.load_base  = status_i.kind inside {KIND_BIN_DATA, KIND_BYTE_DATA};
        cmd_o.read_issue = status_i.kind inside {KIND_READ_BIT, KIND_READ_BYTE};
      end
      ST_BIN_WR: begin
        cmd_o.write_bit   = 1'b1;
        cmd_o.count_frame = status_i.bit_last;
      end
      ST_BYTE_WR: begin
        cmd_o.write_byte  = 1'b1;
        cmd_o.count_frame = status_i.byte_last;
      end
      ST_WIPE: begin
        cmd_o.clear_step = 1'b1;
      end
      ST_RESULT: begin
        cmd_o.load_result = out_free;
      end
      default: ;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_result) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  `SFR_ASSERT(a_result_from_result_state, $rose(out_valid_q) |-> $past(state_q == ST_RESULT), "result shown without passing the result state")
  `SFR_ASSERT(a_accept_goes_decode, (in_valid_i && in_ready_o) |=> state_q == ST_DECODE, "accepted item not decoded next")
  `SFR_ASSERT(a_wipe_then_result, (state_q == ST_WIPE && status_i.clr_last) |=> state_q == ST_RESULT, "store wipe did not end in the result state")
  `SFR_ASSERT(a_failed_ack_no_wipe, (state_q == ST_DECODE && status_i.kind == KIND_ACK && !status_i.ack_start) |=> state_q == ST_RESULT, "non-starting acknowledge wiped a store")
  `SFR_ASSERT_ALWAYS(a_no_accept_in_reset, !rst_ni |-> !in_ready_o, "item accepted during reset")

endmodule

`default_nettype wire

### rtl/sensor_frame_reassembler.sv
// top level of the sensor frame reassembler
// reads and frames that write nothing: decode, then the result state, then back to idle for the next item
// binary data frame: one pixel write per cycle to the bit store
// byte data frame: one pixel write per cycle to the byte store
// starting acknowledge: the store sweep clears one entry per cycle
// after reset both stores are swept before the first item is taken
`default_nettype none

module sensor_frame_reassembler #(
  parameter int unsigned PIXEL_COUNT     = sfr_pkg::PIXEL_COUNT_DEF,
  parameter int unsigned BITS_PER_FRAME  = sfr_pkg::BITS_PER_FRAME_DEF,
  parameter int unsigned BYTES_PER_FRAME = sfr_pkg::BYTES_PER_FRAME_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfr_item_if.sink     in_i,
  sfr_result_if.source out_o,
  sfr_cfg_if.sink      cfg_i
);
  import sfr_pkg::*;

  item_t      item;
  result_t    result;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // register writes are always taken
  assign cfg_i.ready = 1'b1;

  // gather the input item
  assign item.cmd         = in_i.cmd;
  assign item.bus_id      = in_i.bus_id;
  assign item.length      = in_i.length;
  assign item.bytes       = {in_i.byte7, in_i.byte6, in_i.byte5, in_i.byte4,
                             in_i.byte3, in_i.byte2, in_i.byte1, in_i.byte0};
  assign item.pixel_index = in_i.pixel_index;

  sfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sfr_dpath #(
    .PIXEL_COUNT     (PIXEL_COUNT),
    .BITS_PER_FRAME  (BITS_PER_FRAME),
    .BYTES_PER_FRAME (BYTES_PER_FRAME)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .item_i     (item),
    .cmd_i      (cmd),
    .status_o   (status),
    .result_o   (result)
  );

  // spread the result item over the output channel
  assign out_o.success_flag = result.success_flag;
  assign out_o.active_flag  = result.active_flag;
  assign out_o.ready_flag   = result.ready_flag;
  assign out_o.frame_count  = result.frame_count;
  assign out_o.last_number  = result.last_number;
  assign out_o.pixel_value  = result.pixel_value;

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the sensor frame reassembler: directed and random items
module testbench;
  import sfr_pkg::*;

  localparam int unsigned PIXELS = PIXEL_COUNT_DEF;
  localparam int unsigned BITS   = BITS_PER_FRAME_DEF;
  localparam int unsigned BYTES  = BYTES_PER_FRAME_DEF;

  // command code that selects nothing
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // tracks the readout the block should rebuild and the results it owes
  class readout_tracker;
    logic [10:0] ack_id, bin_id, byte_id;
    logic [7:0]  bin_code, byte_code;
    logic [15:0] bin_needed, byte_needed;
    bit          bin_waiting, byte_waiting, acquiring, capture_done, success;
    logic [15:0] frames_seen, last_number;
    bit          bit_pixels[PIXELS];
    logic [7:0]  octet_pixels[PIXELS];
    result_t     expected_readouts[$];
    int unsigned mismatches;

    function new();
      ack_id       = ACK_ID_RST;
      bin_id       = BIN_ID_RST;
      byte_id      = BYTE_ID_RST;
      bin_code     = BIN_CODE_RST;
      byte_code    = BYTE_CODE_RST;
      bin_needed   = BIN_NEEDED_RST;
      byte_needed  = BYTE_NEEDED_RST;
      bin_waiting  = 1'b0;
      byte_waiting = 1'b0;
      acquiring    = 1'b0;
      capture_done = 1'b0;
      success      = 1'b0;
      frames_seen  = '0;
      last_number  = '0;
      foreach (bit_pixels[i]) begin
        bit_pixels[i]   = 1'b0;
        octet_pixels[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [15:0] value);
      case (idx)
        CFG_ACK_ID:      ack_id      = value[10:0];
        CFG_BIN_ID:      bin_id      = value[10:0];
        CFG_BYTE_ID:     byte_id     = value[10:0];
        CFG_BIN_CODE:    bin_code    = value[7:0];
        CFG_BYTE_CODE:   byte_code   = value[7:0];
        CFG_BIN_NEEDED:  bin_needed  = value;
        CFG_BYTE_NEEDED: byte_needed = value;
        default: ;
      endcase
    endfunction

    // one more data frame; true once the capture has all its frames
    function bit count_frame(logic [15:0] number, logic [15:0] needed);
      last_number = number;
      if (frames_seen != 16'hFFFF) frames_seen++;
      if (frames_seen >= needed) begin
        acquiring    = 1'b0;
        capture_done = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_item(item_t it);
      result_t     want;
      int unsigned base;
      int unsigned k;
      logic [15:0] number;
      want = '0;
      case (it.cmd)
        CMD_FRAME: begin
          if (it.bus_id == ack_id && it.length >= LEN_ACK_MIN) begin
            // acknowledge: success always, start or stop only for a request code
            success = (it.bytes[1] != 8'd0);
            if (it.bytes[0] == bin_code || it.bytes[0] == byte_code) begin
              if (!success) begin
                acquiring = 1'b0;
              end else begin
                bin_waiting  = (it.bytes[0] == bin_code);
                byte_waiting = !bin_waiting;
                acquiring    = 1'b1;
                capture_done = 1'b0;
                frames_seen  = '0;
                last_number  = '0;
                if (bin_waiting) foreach (bit_pixels[i]) bit_pixels[i] = 1'b0;
                else foreach (octet_pixels[i]) octet_pixels[i] = '0;
              end
            end
          end else if (it.bus_id == bin_id && bin_waiting && it.length == LEN_DATA) begin
            // one-bit pixels, lsb first from byte 1 on
            number = {8'd0, it.bytes[0]};
            base   = number * BITS;
            for (k = 0; k < BITS; k++)
              if (base + k < PIXELS) bit_pixels[base + k] = it.bytes[1 + k / 8][k % 8];
            if (count_frame(number, bin_needed)) bin_waiting = 1'b0;
          end else if (it.bus_id == byte_id && byte_waiting && it.length == LEN_DATA) begin
            // byte pixels from byte 2 on, little-endian frame number
            number = {it.bytes[1], it.bytes[0]};
            base   = number * BYTES;
            for (k = 0; k < BYTES; k++)
              if (base + k < PIXELS) octet_pixels[base + k] = it.bytes[2 + k];
            if (count_frame(number, byte_needed)) byte_waiting = 1'b0;
          end
        end
        CMD_READ_BIT:
          if (it.pixel_index < PIXELS) want.pixel_value = {7'd0, bit_pixels[it.pixel_index]};
        CMD_READ_BYTE:
          if (it.pixel_index < PIXELS) want.pixel_value = octet_pixels[it.pixel_index];
        default: ;
      endcase
      want.success_flag = success;
      want.active_flag  = acquiring;
      want.ready_flag   = capture_done;
      want.frame_count  = frames_seen;
      want.last_number  = last_number;
      expected_readouts.insert(expected_readouts.size(), want);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 50) $display("mismatch at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_readout(result_t got);
      result_t want;
      if (expected_readouts.size() == 0) begin
        report_mismatch("result with no item outstanding");
        return;
      end
      want = expected_readouts.pop_front();
      if (got.success_flag !== want.success_flag)
        report_mismatch($sformatf("success_flag %b, expected %b",
                                  got.success_flag, want.success_flag));
      if (got.active_flag !== want.active_flag)
        report_mismatch($sformatf("active_flag %b, expected %b",
                                  got.active_flag, want.active_flag));
      if (got.ready_flag !== want.ready_flag)
        report_mismatch($sformatf("ready_flag %b, expected %b",
                                  got.ready_flag, want.ready_flag));
      if (got.frame_count !== want.frame_count)
        report_mismatch($sformatf("frame_count %0d, expected %0d",
                                  got.frame_count, want.frame_count));
      if (got.last_number !== want.last_number)
        report_mismatch($sformatf("last_number %0d, expected %0d",
                                  got.last_number, want.last_number));
      if (got.pixel_value !== want.pixel_value)
        report_mismatch($sformatf("pixel_value %0d, expected %0d",
                                  got.pixel_value, want.pixel_value));
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned send_idle_pct = 33;
  int unsigned sink_idle_pct = 84;
  int unsigned hold_left     = 0;

  readout_tracker books;

  sfr_item_if   item_bus ();
  sfr_result_if result_bus ();
  sfr_cfg_if    cfg_bus ();

  sensor_frame_reassembler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_bus),
    .out_o  (result_bus),
    .cfg_i  (cfg_bus)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // frame with random payload beyond the first two bytes
  function automatic item_t make_frame(logic [10:0] id, logic [3:0] len,
                                       logic [7:0] b0, logic [7:0] b1);
    item_t it;
    it.cmd         = CMD_FRAME;
    it.bus_id      = id;
    it.length      = len;
    it.bytes       = {$urandom, $urandom};
    it.bytes[0]    = b0;
    it.bytes[1]    = b1;
    it.pixel_index = 12'($urandom_range(4095));
    return it;
  endfunction

  function automatic item_t ack_frame(logic [7:0] code, bit ok, logic [3:0] len);
    return make_frame(books.ack_id, len, code, ok ? 8'($urandom_range(255, 1)) : 8'd0);
  endfunction

  function automatic item_t bin_frame(logic [7:0] number);
    return make_frame(books.bin_id, LEN_DATA, number, 8'($urandom));
  endfunction

  function automatic item_t byte_frame(logic [15:0] number);
    return make_frame(books.byte_id, LEN_DATA, number[7:0], number[15:8]);
  endfunction

  function automatic item_t read_item(logic [1:0] cmd, logic [11:0] idx);
    item_t it;
    it = make_frame(11'($urandom_range(2047)), 4'($urandom_range(15)),
                    8'($urandom), 8'($urandom));
    it.cmd         = cmd;
    it.pixel_index = idx;
    return it;
  endfunction

  // anything at all, ids leaning towards the configured ones
  function automatic item_t noise_item();
    item_t       it;
    logic [10:0] id;
    case ($urandom_range(3))
      0: id = books.ack_id;
      1: id = books.bin_id;
      2: id = books.byte_id;
      default: id = 11'($urandom_range(2047));
    endcase
    it     = make_frame(id, 4'($urandom_range(15)), 8'($urandom), 8'($urandom));
    it.cmd = 2'($urandom_range(3));
    return it;
  endfunction

  // offer one item from a falling edge, return at the falling edge after acceptance
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_bus.valid       <= 1'b1;
    item_bus.cmd         <= it.cmd;
    item_bus.bus_id      <= it.bus_id;
    item_bus.length      <= it.length;
    item_bus.byte0       <= it.bytes[0];
    item_bus.byte1       <= it.bytes[1];
    item_bus.byte2       <= it.bytes[2];
    item_bus.byte3       <= it.bytes[3];
    item_bus.byte4       <= it.bytes[4];
    item_bus.byte5       <= it.bytes[5];
    item_bus.byte6       <= it.bytes[6];
    item_bus.byte7       <= it.bytes[7];
    item_bus.pixel_index <= it.pixel_index;
    do @(posedge clk_i); while (!item_bus.ready);
    books.note_item(it);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    books.set_register(idx, value);
    @(negedge clk_i);
  endtask

  task automatic program_registers(input logic [10:0] ack_id, input logic [10:0] bin_id,
                                   input logic [10:0] byte_id, input logic [7:0] bin_code,
                                   input logic [7:0] byte_code, input logic [15:0] bin_needed,
                                   input logic [15:0] byte_needed);
    write_register(CFG_ACK_ID, {5'd0, ack_id});
    write_register(CFG_BIN_ID, {5'd0, bin_id});
    write_register(CFG_BYTE_ID, {5'd0, byte_id});
    write_register(CFG_BIN_CODE, {8'd0, bin_code});
    write_register(CFG_BYTE_CODE, {8'd0, byte_code});
    write_register(CFG_BIN_NEEDED, bin_needed);
    write_register(CFG_BYTE_NEEDED, byte_needed);
    cfg_bus.valid <= 1'b0;
  endtask

  // wait until every result is in and the block has settled
  task automatic drain();
    item_bus.valid <= 1'b0;
    while (books.expected_readouts.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // mostly complete captures with random content, some noise in between
  task automatic run_captures(input int unsigned budget);
    int unsigned sent;
    int unsigned frames;
    int unsigned k;
    int unsigned base;
    bit          binary;
    logic [7:0]  code;
    logic [15:0] needed;
    logic [15:0] number;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(9) < 7) begin
        binary = 1'($urandom_range(1));
        code   = binary ? books.bin_code : books.byte_code;
        needed = binary ? books.bin_needed : books.byte_needed;
        if ($urandom_range(4) == 0) begin
          send_item(ack_frame(code, 1'b0, 4'($urandom_range(15, 2))));
          sent++;
        end
        send_item(ack_frame(code, 1'b1, 4'($urandom_range(15, 2))));
        sent++;
        frames = (needed > 10) ? $urandom_range(10, 4) : needed + $urandom_range(2);
        for (k = 0; k < frames; k++) begin
          if (binary) begin
            number = ($urandom_range(7) == 0) ? 16'($urandom_range(255))
                                              : 16'($urandom_range(65));
            send_item(bin_frame(number[7:0]));
            base = number * BITS + $urandom_range(BITS - 1);
          end else begin
            number = ($urandom_range(7) == 0) ? 16'($urandom_range(65535))
                                              : 16'($urandom_range(607));
            send_item(byte_frame(number));
            base = number * BYTES + $urandom_range(BYTES - 1);
          end
          sent++;
          if ($urandom_range(2) == 0) begin
            send_item(read_item(binary ? CMD_READ_BIT : CMD_READ_BYTE, 12'(base)));
            sent++;
          end
        end
      end else begin
        send_item(noise_item());
        sent++;
      end
    end
  endtask

  // result side: random stalls, or a long hold-off when one is asked for
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready)
      books.check_readout({result_bus.success_flag, result_bus.active_flag,
                           result_bus.ready_flag, result_bus.frame_count,
                           result_bus.last_number, result_bus.pixel_value});
  end

  initial begin : stimulus
    item_t it;
    books = new();
    item_bus.valid       = 1'b0;
    item_bus.cmd         = CMD_FRAME;
    item_bus.bus_id      = '0;
    item_bus.length      = '0;
    item_bus.byte0       = '0;
    item_bus.byte1       = '0;
    item_bus.byte2       = '0;
    item_bus.byte3       = '0;
    item_bus.byte4       = '0;
    item_bus.byte5       = '0;
    item_bus.byte6       = '0;
    item_bus.byte7       = '0;
    item_bus.pixel_index = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = CFG_ACK_ID;
    cfg_bus.data         = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // reads and an unused command before any capture
    send_item(read_item(CMD_READ_BIT, 12'd0));
    send_item(read_item(CMD_READ_BYTE, 12'hFFF));
    send_item(read_item(CMD_UNUSED, 12'd12));
    // too short for an acknowledge, and data with no capture waiting
    send_item(ack_frame(books.bin_code, 1'b1, 4'd1));
    send_item(bin_frame(8'd0));
    // failed request, unrelated command, then a binary start with an over-long length
    send_item(ack_frame(books.bin_code, 1'b0, LEN_ACK_MIN));
    send_item(ack_frame(8'h55, 1'b1, LEN_DATA));
    send_item(ack_frame(books.bin_code, 1'b1, 4'hF));
    // binary frames: wrong length, all ones, partly and wholly past the store
    it = bin_frame(8'd0);
    it.length = 4'd9;
    send_item(it);
    it = bin_frame(8'd0);
    it.bytes[7:1] = '1;
    send_item(it);
    send_item(bin_frame(8'd65));
    send_item(bin_frame(8'hFF));
    send_item(read_item(CMD_READ_BIT, 12'd55));
    send_item(read_item(CMD_READ_BIT, 12'd3647));
    send_item(read_item(CMD_READ_BIT, 12'd3648));
    // byte frame ignored in binary mode, then a byte capture to the store edges
    send_item(byte_frame(16'd5));
    send_item(ack_frame(books.byte_code, 1'b1, LEN_ACK_MIN));
    send_item(byte_frame(16'd0));
    send_item(byte_frame(16'd607));
    send_item(byte_frame(16'd608));
    send_item(byte_frame(16'hFFFF));
    send_item(read_item(CMD_READ_BYTE, 12'd0));
    send_item(read_item(CMD_READ_BYTE, 12'd3647));
    // a failed byte request leaves the capture waiting, so data still counts
    send_item(ack_frame(books.byte_code, 1'b0, LEN_DATA));
    send_item(byte_frame(16'd1));
    send_item(read_item(CMD_READ_BYTE, 12'd6));
    drain();

    // short captures with ids away from their reset values
    program_registers(11'h1A5, 11'h05A, 11'h2C3, 8'h3C, 8'hC3, 16'd3, 16'd5);
    run_captures(115);
    drain();

    // lowest and highest ids and codes, a byte capture that never completes
    send_idle_pct = 84;
    sink_idle_pct = 33;
    program_registers(11'd0, 11'h7FF, 11'h400, 8'hFF, 8'h00, 16'd1, 16'hFFFF);
    run_captures(100);
    drain();

    // no binary frames needed, and both request codes alike so binary wins
    send_idle_pct = 0;
    sink_idle_pct = 0;
    program_registers(11'h7FF, 11'd0, 11'd1, 8'h7E, 8'h7E, 16'd0, 16'd2);
    run_captures(70);
    drain();

    // random ids and codes; results held back for a long stretch at the start
    program_registers(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                      11'($urandom_range(2047)), 8'($urandom), 8'($urandom),
                      16'($urandom_range(6, 1)), 16'($urandom_range(6, 1)));
    hold_left = 400;
    run_captures(70);
    drain();

    if (books.mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // give up if the run hangs
  initial begin : watchdog
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
